FILE: rtl/leg_pkg.sv
// Legendre generator package: datapath widths, microcode word layout,
// microprogram ROM and reciprocal table. No dependencies.

package leg_pkg;

	localparam int DEG_W   = 4;
	localparam int X_W     = 18;
	localparam int CX_W    = 22;   // (2n+1)*x, n <= 15
	localparam int MA_W    = 40;   // cx * P(n)
	localparam int MB_W    = 23;   // n * P(n-1)
	localparam int NUM_W   = 40;   // recurrence numerator, Q.32
	localparam int RCP_W   = 20;   // reciprocal, Q.20
	localparam int PLO_W   = 40;
	localparam int PHI_W   = 41;
	localparam int PROD_W  = 62;   // numerator * reciprocal, Q.52
	localparam int RND_SH  = 36;
	localparam int RES_W   = PROD_W - RND_SH;

	localparam logic signed [X_W-1:0] ONE_Q16 = 18'sd65536;

	typedef logic [2:0] upc_t;

	typedef enum logic [1:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_INPUT
	} cond_t;

	typedef enum logic [1:0] {
		SEL_ONE,
		SEL_X,
		SEL_REC
	} sel_t;

	typedef struct packed {
		logic  load_x;
		logic  emit;
		sel_t  sel;
		logic  ld_mul;
		logic  ld_num;
		logic  ld_rmul;
		logic  ld_next;
		cond_t cond;
		upc_t  target;
	} ctrl_t;

	localparam upc_t UPC_WAIT = 3'd0;
	localparam upc_t UPC_P0   = 3'd1;
	localparam upc_t UPC_P1   = 3'd2;
	localparam upc_t UPC_MUL  = 3'd3;
	localparam upc_t UPC_SUB  = 3'd4;
	localparam upc_t UPC_RMUL = 3'd5;
	localparam upc_t UPC_RND  = 3'd6;

	// Microprogram. An emitted top-degree result ends the program (back to wait).
	function automatic ctrl_t ucode(upc_t pc);
		ctrl_t c;
		c = '{load_x: 1'b0, emit: 1'b0, sel: SEL_ONE, ld_mul: 1'b0, ld_num: 1'b0,
		      ld_rmul: 1'b0, ld_next: 1'b0, cond: COND_NEVER, target: UPC_WAIT};
		unique case (pc)
			UPC_WAIT: begin
				c.load_x = 1'b1;
				c.cond   = COND_NO_INPUT;
				c.target = UPC_WAIT;
			end
			UPC_P0: begin
				c.emit = 1'b1;
				c.sel  = SEL_ONE;
			end
			UPC_P1: begin
				c.emit = 1'b1;
				c.sel  = SEL_X;
			end
			UPC_MUL:  c.ld_mul  = 1'b1;
			UPC_SUB:  c.ld_num  = 1'b1;
			UPC_RMUL: c.ld_rmul = 1'b1;
			UPC_RND: begin
				c.emit    = 1'b1;
				c.sel     = SEL_REC;
				c.ld_next = 1'b1;
				c.cond    = COND_ALWAYS;
				c.target  = UPC_MUL;
			end
			default: begin
				c.cond   = COND_ALWAYS;
				c.target = UPC_WAIT;
			end
		endcase
		return c;
	endfunction

	// round(2^20 / (n+1)), ties up
	function automatic logic [RCP_W-1:0] recip(logic [DEG_W-1:0] n);
		logic [RCP_W-1:0] r;
		unique case (n)
			4'd1:    r = 20'd524288;
			4'd2:    r = 20'd349525;
			4'd3:    r = 20'd262144;
			4'd4:    r = 20'd209715;
			4'd5:    r = 20'd174763;
			4'd6:    r = 20'd149797;
			4'd7:    r = 20'd131072;
			4'd8:    r = 20'd116508;
			4'd9:    r = 20'd104858;
			4'd10:   r = 20'd95325;
			4'd11:   r = 20'd87381;
			4'd12:   r = 20'd80660;
			4'd13:   r = 20'd74898;
			4'd14:   r = 20'd69905;
			default: r = 20'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/legendre_polynomial_generator.sv
// Legendre polynomial generator, top level: microcoded sequencer and datapath.
// Depends on leg_pkg.
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready/cfg_data) writes top_degree; always
//    ready. Write only while the block is idle. Reset value is 15; the value
//    used is min(top_degree, MAX_DEGREE).
//  - Input channel: one item per argument x_value (signed Q1.16, clamped to
//    [-1,1]). An item is taken when in_valid is high and in_stall is low.
//  - Output channel: one item per degree, P0 up to P(top), ascending, with
//    last set on the top degree. Taken when out_valid high and out_stall low.
//  - Sequence: the input is taken in wait, P0 and P1 are emitted from their
//    own steps, and every further degree takes one pass through the
//    MUL/SUB/RMUL/RND microprogram loop and is emitted from RND. The
//    sequencer returns to wait as the last result is loaded; the next argument
//    can be taken on the cycle after the last result is loaded.
//  - A stalled output holds its item; an emitting step waits on it, so the
//    sequencer freezes until the item is taken.
//  - Reset returns the step counter to wait, drops output valid and sets
//    top_degree to 15.

module legendre_polynomial_generator
	import leg_pkg::*;
#(
	parameter int MAX_DEGREE = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [DEG_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [X_W-1:0] x_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DEG_W-1:0]      degree,
	output logic signed [X_W-1:0] poly_value,
	output logic                  last
);

	// control
	upc_t             pc_q;
	upc_t             pc_next;
	ctrl_t            cw;
	logic [DEG_W-1:0] top_degree_q;
	logic [DEG_W-1:0] top_eff;
	logic             in_take;
	logic             hold;

	// datapath registers
	logic signed [X_W-1:0]   x_q;
	logic signed [X_W-1:0]   pn_q;       // P(n)
	logic signed [X_W-1:0]   pm_q;       // P(n-1)
	logic [DEG_W-1:0]        n_q;
	logic signed [CX_W-1:0]  cx_q;       // (2n+1)*x
	logic signed [MA_W-1:0]  ma_q;
	logic signed [MB_W-1:0]  mb_q;
	logic signed [NUM_W-1:0] num_q;
	logic [PLO_W-1:0]        plo_q;
	logic signed [PHI_W-1:0] phi_q;

	// datapath logic
	logic signed [X_W-1:0]    x_sat;
	logic signed [MA_W-1:0]   ma_w;
	logic signed [MB_W-1:0]   mb_w;
	logic [RCP_W-1:0]         rcp;
	logic signed [PROD_W-1:0] rnd_w;
	logic signed [RES_W-1:0]  res_w;
	logic signed [X_W-1:0]    rec_val;

	// emit selection
	logic [DEG_W-1:0]      emit_deg;
	logic signed [X_W-1:0] emit_val;
	logic                  emit_last;

	// output register
	logic                  out_valid_q;
	logic [DEG_W-1:0]      degree_q;
	logic signed [X_W-1:0] poly_value_q;
	logic                  last_q;

	assign cw        = ucode(pc_q);
	assign cfg_ready = 1'b1;
	assign in_stall  = !cw.load_x;
	assign in_take   = cw.load_x && in_valid;
	assign hold      = cw.emit && out_valid_q && out_stall;

	assign top_eff = (int'(top_degree_q) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : top_degree_q;

	// argument clamp to [-1, 1]
	always_comb begin
		if (x_value > ONE_Q16)
			x_sat = ONE_Q16;
		else if (x_value < -ONE_Q16)
			x_sat = -ONE_Q16;
		else
			x_sat = x_value;
	end

	assign ma_w = cx_q * pn_q;
	assign mb_w = $signed({1'b0, n_q}) * pm_q;
	assign rcp  = recip(n_q);

	// num * R, plus the round bias (ties away from zero), one three-input add.
	// Sign of the product is the sign of the numerator since R > 0.
	always_comb begin
		rnd_w = (PROD_W'(phi_q) <<< RCP_W) + $signed({{(PROD_W-PLO_W){1'b0}}, plo_q})
		      + (num_q[NUM_W-1] ? (PROD_W'(1) <<< (RND_SH-1)) - PROD_W'(1)
		                        : (PROD_W'(1) <<< (RND_SH-1)));
		res_w = rnd_w[PROD_W-1:RND_SH];
		if (res_w > RES_W'(ONE_Q16))
			rec_val = ONE_Q16;
		else if (res_w < -RES_W'(ONE_Q16))
			rec_val = -ONE_Q16;
		else
			rec_val = res_w[X_W-1:0];
	end

	always_comb begin
		unique case (cw.sel)
			SEL_ONE: begin
				emit_deg = '0;
				emit_val = ONE_Q16;
			end
			SEL_X: begin
				emit_deg = DEG_W'(1);
				emit_val = pn_q;
			end
			SEL_REC: begin
				emit_deg = n_q + DEG_W'(1);
				emit_val = rec_val;
			end
			default: begin
				emit_deg = '0;
				emit_val = ONE_Q16;
			end
		endcase
		emit_last = (emit_deg == top_eff);
	end

	// sequencer
	always_comb begin
		if (hold)
			pc_next = pc_q;
		else if (cw.emit && emit_last)
			pc_next = UPC_WAIT;
		else begin
			unique case (cw.cond)
				COND_ALWAYS:   pc_next = cw.target;
				COND_NO_INPUT: pc_next = in_take ? pc_q + upc_t'(1) : cw.target;
				default:       pc_next = pc_q + upc_t'(1);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q         <= UPC_WAIT;
			top_degree_q <= DEG_W'(15);
			out_valid_q  <= 1'b0;
		end else begin
			pc_q <= pc_next;
			if (cfg_valid)
				top_degree_q <= cfg_data;
			if (cw.emit && !hold)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (in_take) begin
			x_q  <= x_sat;
			pn_q <= x_sat;
			pm_q <= ONE_Q16;
			n_q  <= DEG_W'(1);
			cx_q <= CX_W'(x_sat) + (CX_W'(x_sat) <<< 1);
		end
		if (cw.ld_mul) begin
			ma_q <= ma_w;
			mb_q <= mb_w;
		end
		if (cw.ld_num)
			num_q <= ma_q - (NUM_W'(mb_q) <<< 16);
		if (cw.ld_rmul) begin
			plo_q <= num_q[RCP_W-1:0] * rcp;
			phi_q <= $signed(num_q[NUM_W-1:RCP_W]) * $signed({1'b0, rcp});
		end
		if (cw.ld_next && !hold) begin
			pm_q <= pn_q;
			pn_q <= rec_val;
			n_q  <= n_q + DEG_W'(1);
			cx_q <= cx_q + (CX_W'(x_q) <<< 1);
		end
		if (cw.emit && !hold) begin
			degree_q     <= emit_deg;
			poly_value_q <= emit_val;
			last_q       <= emit_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign degree     = degree_q;
	assign poly_value = poly_value_q;
	assign last       = last_q;

endmodule

FILE: rtl/leg_checker.sv
// Port-level checker for the Legendre generator, bound to the top level.
// Depends on nothing but the top level's port names.

module leg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [3:0]         degree,
	input logic signed [17:0] poly_value,
	input logic               last
);

	// stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(degree) && $stable(poly_value)
		                           && $stable(last))
		else $error("stalled output item changed");

	// results stay inside [-1, 1]
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (poly_value <= 18'sd65536) && (poly_value >= -18'sd65536))
		else $error("poly_value out of range");

	// P0 is always one
	a_p0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (degree == 4'd0) |-> poly_value == 18'sd65536)
		else $error("P0 not one");

	// one argument at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

endmodule

bind legendre_polynomial_generator leg_checker u_leg_checker (.*);

FILE: verif/legendre_polynomial_generator_tb.sv
// Testbench for legendre_polynomial_generator: drives x arguments and top_degree writes,
// predicts P0..Pk for every argument and checks each result item in order.
// Depends on leg_pkg and the legendre_polynomial_generator RTL.

module legendre_polynomial_generator_tb
	import leg_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int     MAX_DEG = 15;
	localparam longint UNIT    = 65536;   // 1.0 in Q1.16

	// one expected result item: degree, value, last flag
	typedef struct {
		logic [DEG_W-1:0]      deg;
		logic signed [X_W-1:0] val;
		logic                  last;
	} poly_result_t;

	// Expected-result store plus the Bonnet recurrence predictor.
	class legendre_scoreboard;
		poly_result_t pending_q[$];
		int unsigned  n_args;
		int unsigned  n_checked;
		int unsigned  n_errors;

		task report(string msg);
			n_errors++;
			if (n_errors <= 40)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
		endtask

		// Queue the whole P0..P(top) series for one accepted argument.
		function void note_argument(logic signed [X_W-1:0] x, int unsigned top);
			longint      xc, p_prev, p_cur, num, rcp, prod, mag, q;
			int unsigned hi;
			hi = (top > MAX_DEG) ? MAX_DEG : top;
			xc = x;
			// arguments outside [-1,1] are clamped first, P1 included
			if (xc > UNIT)
				xc = UNIT;
			if (xc < -UNIT)
				xc = -UNIT;
			n_args++;
			pending_q.push_back('{DEG_W'(0), X_W'(UNIT), hi == 0});
			if (hi == 0)
				return;
			pending_q.push_back('{DEG_W'(1), X_W'(xc), hi == 1});
			p_prev = UNIT;
			p_cur  = xc;
			for (int n = 1; n < hi; n++) begin
				// numerator in Q.32, reciprocal of n+1 in Q.20 rounded ties up
				num  = (2 * n + 1) * xc * p_cur - n * p_prev * UNIT;
				rcp  = ((longint'(1) << 21) / (n + 1) + 1) >>> 1;
				prod = num * rcp;
				mag  = (prod < 0) ? -prod : prod;
				// back to Q1.16: round half away from zero, then saturate
				q = (mag + (longint'(1) << 35)) >>> 36;
				if (q > UNIT)
					q = UNIT;
				p_prev = p_cur;
				p_cur  = (prod < 0) ? -q : q;
				pending_q.push_back('{DEG_W'(n + 1), X_W'(p_cur), (n + 1) == hi});
			end
		endfunction

		task check_result(logic [DEG_W-1:0] d, logic signed [X_W-1:0] v, logic l);
			poly_result_t want;
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected item: degree %0d value %0d last %0b", d, v, l));
				return;
			end
			want = pending_q.pop_front();
			n_checked++;
			if (d !== want.deg)
				report($sformatf("degree %0d, want %0d", d, want.deg));
			if (v !== want.val)
				report($sformatf("P%0d value %0d, want %0d", want.deg, v, want.val));
			if (l !== want.last)
				report($sformatf("P%0d last %0b, want %0b", want.deg, l, want.last));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [DEG_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic signed [X_W-1:0] x_value;
	logic                  out_valid;
	logic                  out_stall;
	logic [DEG_W-1:0]      degree;
	logic signed [X_W-1:0] poly_value;
	logic                  last;

	legendre_scoreboard sb;
	int unsigned        top_now;       // our copy of top_degree
	int unsigned        n_cfg_writes;

	legendre_polynomial_generator #(
		.MAX_DEGREE(MAX_DEG)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.x_value   (x_value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.degree    (degree),
		.poly_value(poly_value),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run (~500 arguments x 16
	// results, each under heavy output stalls).
	initial begin
		#8ms;
		$display("legendre_polynomial_generator test failed");
		$finish;
	end

	// Output monitor. Sampled at the rising edge, before any update of this
	// step lands, so the item seen is the one the edge accepts.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(degree, poly_value, last);
	end

	// Receiver back-pressure: switches between a free-running stretch,
	// light random stalls, heavy random stalls and a fixed periodic pattern.
	initial begin : stall_gen
		int          mode;
		int          mode_left;
		int unsigned cyc;
		mode      = 0;
		mode_left = 0;
		cyc       = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 9) < 7);
				default: out_stall <= ((cyc % 5) < 2);
			endcase
		end
	end

	// Offer one argument; valid stays up until the edge that takes it.
	// The prediction is made with the degree setting in force right now.
	task automatic send_arg(logic signed [X_W-1:0] x);
		in_valid <= 1'b1;
		x_value  <= x;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_argument(x, top_now);
	endtask

	task automatic idle_input(int unsigned cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stop sending, let every expected item come back, then give the
	// sequencer time to settle back to its wait state.
	task automatic drain_outputs();
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Only called with the block idle (after drain_outputs).
	task automatic write_top_degree(int unsigned top);
		cfg_valid <= 1'b1;
		cfg_data  <= DEG_W'(top);
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		top_now = top;
		n_cfg_writes++;
	endtask

	// Mostly in-range arguments; some unit corners and some raw 18-bit
	// patterns so that the clamp sees large magnitudes of both signs.
	function automatic logic signed [X_W-1:0] pick_arg();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			return X_W'($urandom);
		if (sel < 16) begin
			case ($urandom_range(0, 5))
				0: return X_W'(UNIT);
				1: return X_W'(-UNIT);
				2: return X_W'(0);
				3: return X_W'(UNIT - 1);
				4: return X_W'(-UNIT + 1);
				default: return X_W'(1);
			endcase
		end
		return X_W'(int'($urandom_range(0, 2 * UNIT)) - int'(UNIT));
	endfunction

	// A run of random arguments sent in bursts with random gaps; long bursts
	// now and then give stretches without any input idling.
	task automatic random_phase(int unsigned count, bit pause_midway);
		int unsigned burst_left;
		burst_left = 0;
		for (int unsigned i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2)
				drain_outputs();
			if (burst_left == 0) begin
				if ($urandom_range(0, 2) != 0)
					idle_input($urandom_range(1, 12));
				burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 20);
			end
			send_arg(pick_arg());
			burst_left--;
		end
	endtask

	logic signed [X_W-1:0] edge_args[] = '{
		18'sd0, 18'sd65536, -18'sd65536, 18'sd1, -18'sd1, 18'sd32768, -18'sd32768,
		18'sd65535, -18'sd65535, 18'sd131071, -18'sd131072, 18'sd65537, -18'sd65537,
		18'sd98304, 18'sh15555, 18'sh2AAAA, 18'sd23170, -18'sd45000
	};

	// degree settings per random phase; the rest are drawn at random
	int unsigned phase_tops[] = '{0, 1, 15, 2, 14, 7};

	initial begin
		sb           = new();
		top_now      = 15;           // reset value of top_degree
		n_cfg_writes = 0;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		x_value      = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: unit corners, clamp cases, alternating bit patterns,
		// all at the reset degree setting (full 16-term series)
		foreach (edge_args[i])
			send_arg(edge_args[i]);
		drain_outputs();

		// single-term setting with the same corners
		write_top_degree(0);
		for (int i = 0; i < 4; i++)
			send_arg(edge_args[i]);
		drain_outputs();

		for (int p = 0; p < 10; p++) begin
			write_top_degree(p < phase_tops.size() ? phase_tops[p] : $urandom_range(0, 15));
			random_phase(44, p == 4);
			drain_outputs();
		end

		$display("Ran %0d arguments over %0d degree settings, %0d result items checked.",
			sb.n_args, n_cfg_writes + 1, sb.n_checked);
		if (sb.pending_q.size() != 0)
			sb.report($sformatf("%0d expected items never arrived", sb.pending_q.size()));
		if (sb.n_errors == 0)
			$display("legendre_polynomial_generator test passed");
		else
			$display("legendre_polynomial_generator test failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/leg_pkg.sv
rtl/legendre_polynomial_generator.sv
rtl/leg_checker.sv
verif/legendre_polynomial_generator_tb.sv
